/* sv/atmo_pkg.sv */
// atmo_pkg: shared types and constants of the trimmed-mean overcurrent filter
// no dependencies; imported by every module of the block
package atmo_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 18;
	localparam int IDX_W    = 6;
	localparam int CUR_W    = 13;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [CUR_W-1:0] cur_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_A    = 2'd0,
		CFG_OFFSET_B    = 2'd1,
		CFG_LIMIT       = 2'd2,
		CFG_TRIP_PERIOD = 2'd3
	} cfg_idx_t;

	localparam sample_t RST_OFFSET      = 12'd2048;
	localparam sample_t RST_LIMIT       = 12'd413;
	localparam cnt_t    RST_TRIP_PERIOD = 16'd20000;

	// running statistics of one phase over a window
	typedef struct packed {
		sum_t    sum;
		sample_t smax;
		sample_t smin;
	} chan_t;

	typedef struct packed {
		chan_t [1:0] ch;
		logic        drive;
	} win_t;

	typedef struct packed {
		sample_t [1:0] mean;
		logic          drive;
	} mean_t;

	typedef struct packed {
		sample_t offset_a;
		sample_t offset_b;
		sample_t limit;
		cnt_t    trip_period;
	} cfg_t;

endpackage

/* sv/atmo_window.sv */
// atmo_window: per-window running sum, max and min of both phases
// depends on atmo_pkg; feeds the closed window to atmo_divide
module atmo_window import atmo_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  sample_t sample_a,
	input  sample_t sample_b,
	input  logic    drive_enabled,
	input  logic    win_take,
	output logic    win_last,
	output logic    win_valid,
	output win_t    win_s1
);

	localparam idx_t LAST_IDX  = IDX_W'(WINDOW - 1);
	localparam idx_t FIRST_IDX = IDX_W'(1);
	localparam idx_t SKIP_IDX  = IDX_W'(0);

	idx_t    idx_q;
	sum_t    sum_q [2];
	sample_t max_q [2];
	sample_t min_q [2];
	sample_t smp [2];
	chan_t   acc_d [2];

	assign win_last = (idx_q == LAST_IDX);

	always_comb begin
		smp[0] = sample_a;
		smp[1] = sample_b;
		for (int ch = 0; ch < 2; ch++) begin
			if (idx_q == FIRST_IDX) begin
				acc_d[ch].sum  = sum_t'(smp[ch]);
				acc_d[ch].smax = smp[ch];
				acc_d[ch].smin = smp[ch];
			end else begin
				acc_d[ch].sum  = sum_q[ch] + sum_t'(smp[ch]);
				acc_d[ch].smax = (smp[ch] > max_q[ch]) ? smp[ch] : max_q[ch];
				acc_d[ch].smin = (smp[ch] < min_q[ch]) ? smp[ch] : min_q[ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			sum_q[0]  <= '0;
			sum_q[1]  <= '0;
			win_valid <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= win_last ? '0 : idx_q + IDX_W'(1);
				// first request of a window is thrown away
				if (idx_q != SKIP_IDX) begin
					sum_q[0] <= acc_d[0].sum;
					sum_q[1] <= acc_d[1].sum;
				end
			end
			win_valid <= (win_valid && !win_take) || (accept && win_last);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && idx_q != SKIP_IDX) begin
			for (int ch = 0; ch < 2; ch++) begin
				max_q[ch] <= acc_d[ch].smax;
				min_q[ch] <= acc_d[ch].smin;
			end
		end
		if (accept && win_last) begin
			win_s1.ch[0] <= acc_d[0];
			win_s1.ch[1] <= acc_d[1];
			win_s1.drive <= drive_enabled;
		end
	end

endmodule

/* sv/atmo_divide.sv */
// atmo_divide: trimmed sum and division by the constant WINDOW-3
// depends on atmo_pkg; sits between atmo_window and atmo_trip
module atmo_divide import atmo_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  win_valid,
	input  win_t  win_s1,
	output logic  win_take,
	input  logic  mean_take,
	output logic  mean_valid,
	output mean_t mean_s2
);

	// exact reciprocal: floor(t*m >> sh) == t / DIV for every t below 2^SUM_W
	localparam int    DIV     = WINDOW - 3;
	localparam int    DIV_SH  = SUM_W + $clog2(DIV);
	localparam longint RECIP  = ((64'd1 << DIV_SH) + DIV - 1) / DIV;
	localparam int    RECIP_W = SUM_W + 2;
	localparam int    PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	sum_t              trim [2];
	logic [PROD_W-1:0] prod [2];
	sample_t           quot [2];

	assign win_take = win_valid && (!mean_valid || mean_take);

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			trim[ch] = win_s1.ch[ch].sum - sum_t'(win_s1.ch[ch].smax)
				- sum_t'(win_s1.ch[ch].smin);
			prod[ch] = PROD_W'(trim[ch]) * PROD_W'(RECIP_C);
			quot[ch] = prod[ch][DIV_SH +: SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_valid <= 1'b0;
		end else begin
			mean_valid <= (mean_valid && !mean_take) || win_take;
		end
	end

	always_ff @(posedge clk) begin
		if (win_take) begin
			mean_s2.mean[0] <= quot[0];
			mean_s2.mean[1] <= quot[1];
			mean_s2.drive   <= win_s1.drive;
		end
	end

endmodule

/* sv/atmo_trip.sv */
// atmo_trip: offset removal, limit compare, overcurrent counter and result register
// depends on atmo_pkg; fed by atmo_divide
module atmo_trip import atmo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    mean_valid,
	input  mean_t   mean_s2,
	output logic    mean_take,
	output logic    result_valid,
	input  logic    result_stall,
	output sample_t mean_a,
	output sample_t mean_b,
	output cur_t    current_a,
	output cur_t    current_b,
	output logic    over_limit,
	output logic    trip
);

	cnt_t    count_q;
	cnt_t    count_inc;
	cnt_t    count_d;
	cur_t    cur [2];
	cur_t    mag [2];
	sample_t offs [2];
	logic    over;
	logic    trip_d;

	sample_t mean_a_s3;
	sample_t mean_b_s3;
	cur_t    current_a_s3;
	cur_t    current_b_s3;
	logic    over_s3;
	logic    trip_s3;

	assign mean_take = mean_valid && (!result_valid || !result_stall);

	always_comb begin
		offs[0] = cfg.offset_a;
		offs[1] = cfg.offset_b;
		for (int ch = 0; ch < 2; ch++) begin
			cur[ch] = cur_t'({1'b0, mean_s2.mean[ch]}) - cur_t'({1'b0, offs[ch]});
			mag[ch] = cur[ch][CUR_W-1] ? -cur[ch] : cur[ch];
		end
		over = (mag[0] > cur_t'({1'b0, cfg.limit})) || (mag[1] > cur_t'({1'b0, cfg.limit}));

		count_inc = count_q + CNT_W'(1);
		count_d   = '0;
		trip_d    = 1'b0;
		if (over) begin
			count_d = count_inc;
			if (mean_s2.drive) begin
				// trip at half the period while driving
				if (count_inc == (cfg.trip_period >> 1)) begin
					count_d = '0;
					trip_d  = 1'b1;
				end
			end else if (count_inc == cfg.trip_period) begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			if (mean_take) begin
				count_q <= count_d;
			end
			result_valid <= (result_valid && result_stall) || mean_take;
		end
	end

	always_ff @(posedge clk) begin
		if (mean_take) begin
			mean_a_s3    <= mean_s2.mean[0];
			mean_b_s3    <= mean_s2.mean[1];
			current_a_s3 <= cur[0];
			current_b_s3 <= cur[1];
			over_s3      <= over;
			trip_s3      <= trip_d;
		end
	end

	assign mean_a     = mean_a_s3;
	assign mean_b     = mean_b_s3;
	assign current_a  = current_a_s3;
	assign current_b  = current_b_s3;
	assign over_limit = over_s3;
	assign trip       = trip_s3;

endmodule

/* sv/adc_trimmed_mean_overcurrent.sv */
// adc_trimmed_mean_overcurrent: one request per cycle unless sample_stall holds it; one result per WINDOW requests
// the window's last request passes the window, divide and trip registers in turn on its way to result_valid
// throughput: a request every cycle; the window's last request waits only when the
// three-deep result pipeline is full behind a stalled result
// reset: window index, sums, counter and pipeline valids clear; config registers take defaults
// depends on atmo_pkg, atmo_window, atmo_divide, atmo_trip
module adc_trimmed_mean_overcurrent import atmo_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample_a,
	input  sample_t               sample_b,
	input  logic                  drive_enabled,
	output logic                  result_valid,
	input  logic                  result_stall,
	output sample_t               mean_a,
	output sample_t               mean_b,
	output cur_t                  current_a,
	output cur_t                  current_b,
	output logic                  over_limit,
	output logic                  trip,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  accept;
	logic  win_last;
	logic  win_valid;
	logic  win_take;
	win_t  win_s1;
	logic  mean_valid;
	logic  mean_take;
	mean_t mean_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_a    <= RST_OFFSET;
			cfg_q.offset_b    <= RST_OFFSET;
			cfg_q.limit       <= RST_LIMIT;
			cfg_q.trip_period <= RST_TRIP_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFFSET_A:    cfg_q.offset_a    <= cfg_data[SAMPLE_W-1:0];
				CFG_OFFSET_B:    cfg_q.offset_b    <= cfg_data[SAMPLE_W-1:0];
				CFG_LIMIT:       cfg_q.limit       <= cfg_data[SAMPLE_W-1:0];
				CFG_TRIP_PERIOD: cfg_q.trip_period <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// only the closing request needs room in the pipeline
	assign sample_stall = win_last && win_valid && !win_take;
	assign accept       = sample_valid && !sample_stall;

	atmo_window #(.WINDOW(WINDOW)) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.drive_enabled (drive_enabled),
		.win_take      (win_take),
		.win_last      (win_last),
		.win_valid     (win_valid),
		.win_s1        (win_s1)
	);

	atmo_divide #(.WINDOW(WINDOW)) u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win_s1     (win_s1),
		.win_take   (win_take),
		.mean_take  (mean_take),
		.mean_valid (mean_valid),
		.mean_s2    (mean_s2)
	);

	atmo_trip u_trip (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.mean_valid   (mean_valid),
		.mean_s2      (mean_s2),
		.mean_take    (mean_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mean_a       (mean_a),
		.mean_b       (mean_b),
		.current_a    (current_a),
		.current_b    (current_b),
		.over_limit   (over_limit),
		.trip         (trip)
	);

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> win_last)
		else $error("request stalled outside the window's last slot");

	a_close_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && win_last |=> win_valid)
		else $error("closed window not captured");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		win_take |-> win_valid)
		else $error("divide stage took an empty window");

	a_trip_over: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && trip |-> over_limit)
		else $error("trip without overcurrent");

endmodule
